// ===== sv/cfr_pkg.sv =====
// shared constants for the checksum frame receiver
`default_nettype none

package cfr_pkg;

    // default payload length limit (lengths must stay below it)
    localparam int LENGTH_LIMIT_DEF = 50;

    // field widths
    localparam int BYTE_W  = 8;
    localparam int INDEX_W = 6;

    // function byte must be strictly above this floor
    localparam logic [BYTE_W-1:0] FUNC_FLOOR = 8'hF0;

    // configuration register map
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_SECOND = 2'd1;

    // register reset values
    localparam logic [BYTE_W-1:0] HEADER_FIRST_RST  = 8'hAA;
    localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'hAF;

endpackage

`default_nettype wire

// ===== sv/cfr_ram.sv =====
// generic single-port-write, registered-read ram
`default_nettype none

module cfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 49,
    localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AddrW-1:0] waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AddrW-1:0] raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, holds between reads
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/checksum_frame_receiver.sv =====
// checksum frame receiver: header/length/sum8 deframer with payload ram
//
// Input channel (s_*): one received byte per transaction. While a frame is
// being received, s_ready is high and one byte is taken each valid cycle.
// Frame: header_first, header_second, function byte above 0xF0, length byte
// below LENGTH_LIMIT, that many payload bytes, 8-bit additive checksum.
// Payload bytes are written into a ram of LENGTH_LIMIT-1 entries.
// Result channel (m_*): on a matching checksum the stored payload is read
// back and sent one transaction per byte, tagged with the function code and
// its index; m_last_byte marks the final one. Each payload byte is read out
// by a ram read, then a load into the output register, as set by the single
// registered read port of the payload ram; s_ready is low during readout.
// A stalled receiver (m_ready low) holds the output register and readout.
// Once the last result is loaded, input is taken again even while it waits.
// Configuration (cfg_*): write-only, header_first at index 0, header_second
// at index 1; other indexes are ignored. Write only while the block is idle.
// Reset (aresetn low, synchronous): hunting state, headers 0xAA and 0xAF,
// no result pending; the ram needs no clearing.
`default_nettype none

module checksum_frame_receiver #(
    parameter int LENGTH_LIMIT = cfr_pkg::LENGTH_LIMIT_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // configuration port
    input  wire logic                          cfg_we,
    input  wire logic [cfr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [cfr_pkg::BYTE_W-1:0]    cfg_wdata,
    // input channel
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [cfr_pkg::BYTE_W-1:0]    s_rx_byte,
    // result channel
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [cfr_pkg::BYTE_W-1:0]    m_function_code,
    output logic      [cfr_pkg::BYTE_W-1:0]    m_payload_byte,
    output logic      [cfr_pkg::INDEX_W-1:0]   m_byte_index,
    output logic                               m_last_byte
);

    localparam int Depth = LENGTH_LIMIT - 1;
    localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW  = cfr_pkg::INDEX_W;
    localparam logic [cfr_pkg::BYTE_W-1:0] LimitByte = cfr_pkg::BYTE_W'(LENGTH_LIMIT);

    typedef enum logic [7:0] {
        ST_HUNT    = 8'b0000_0001,
        ST_HDR1    = 8'b0000_0010,
        ST_HDR2    = 8'b0000_0100,
        ST_FUNC    = 8'b0000_1000,
        ST_PAYLOAD = 8'b0001_0000,
        ST_CSUM    = 8'b0010_0000,
        ST_READ    = 8'b0100_0000,
        ST_LOAD    = 8'b1000_0000
    } state_t;

    state_t                      state_reg, state_next;
    logic [cfr_pkg::BYTE_W-1:0]  hdr_first_reg, hdr_second_reg;
    logic [CntW-1:0]             remaining_reg, remaining_next;
    logic [CntW-1:0]             stored_reg, stored_next;
    logic [CntW-1:0]             rd_idx_reg, rd_idx_next;
    logic [cfr_pkg::BYTE_W-1:0]  sum_reg, sum_next;
    logic [cfr_pkg::BYTE_W-1:0]  func_reg, func_next;

    logic                        m_valid_reg;
    logic [cfr_pkg::BYTE_W-1:0]  m_func_reg;
    logic [cfr_pkg::BYTE_W-1:0]  m_data_reg;
    logic [CntW-1:0]             m_index_reg;
    logic                        m_last_reg;

    logic                        s_accept;
    logic                        ram_we;
    logic                        ram_re;
    logic [cfr_pkg::BYTE_W-1:0]  ram_rdata;
    logic                        load;
    logic                        rd_last;

    // input is taken in the receive states only
    assign s_ready  = (state_reg inside {ST_HUNT, ST_HDR1, ST_HDR2, ST_FUNC,
                                         ST_PAYLOAD, ST_CSUM});
    assign s_accept = s_valid && s_ready;

    // payload write and readout
    assign ram_we  = s_accept && (state_reg == ST_PAYLOAD) && (remaining_reg != '0);
    assign ram_re  = (state_reg == ST_READ);
    assign load    = (state_reg == ST_LOAD) && (!m_valid_reg || m_ready);
    assign rd_last = ((rd_idx_reg + CntW'(1)) == stored_reg);

    cfr_ram #(
        .WIDTH (cfr_pkg::BYTE_W),
        .DEPTH (Depth)
    ) u_payload_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (stored_reg[AddrW-1:0]),
        .wdata (s_rx_byte),
        .re    (ram_re),
        .raddr (rd_idx_reg[AddrW-1:0]),
        .rdata (ram_rdata)
    );

    // frame sequencer
    always_comb begin
        state_next     = state_reg;
        remaining_next = remaining_reg;
        stored_next    = stored_reg;
        rd_idx_next    = rd_idx_reg;
        sum_next       = sum_reg;
        func_next      = func_reg;
        case (state_reg)
            ST_HUNT: begin
                if (s_accept && (s_rx_byte == hdr_first_reg)) begin
                    state_next = ST_HDR1;
                    sum_next   = s_rx_byte;
                end
            end
            ST_HDR1: begin
                if (s_accept) begin
                    if (s_rx_byte == hdr_second_reg) begin
                        state_next = ST_HDR2;
                        sum_next   = sum_reg + s_rx_byte;
                    end else begin
                        state_next = ST_HUNT;
                    end
                end
            end
            ST_HDR2: begin
                if (s_accept) begin
                    if (s_rx_byte > cfr_pkg::FUNC_FLOOR) begin
                        state_next = ST_FUNC;
                        func_next  = s_rx_byte;
                        sum_next   = sum_reg + s_rx_byte;
                    end else begin
                        state_next = ST_HUNT;
                    end
                end
            end
            ST_FUNC: begin
                if (s_accept) begin
                    if (s_rx_byte < LimitByte) begin
                        state_next     = ST_PAYLOAD;
                        remaining_next = s_rx_byte[CntW-1:0];
                        stored_next    = '0;
                        sum_next       = sum_reg + s_rx_byte;
                    end else begin
                        state_next = ST_HUNT;
                    end
                end
            end
            ST_PAYLOAD: begin
                if (s_accept) begin
                    if (remaining_reg != '0) begin
                        stored_next    = stored_reg + CntW'(1);
                        remaining_next = remaining_reg - CntW'(1);
                        sum_next       = sum_reg + s_rx_byte;
                        if (remaining_reg == CntW'(1)) begin
                            state_next = ST_CSUM;
                        end
                    end else begin
                        // zero length: frame dropped
                        state_next = ST_HUNT;
                    end
                end
            end
            ST_CSUM: begin
                if (s_accept) begin
                    if (s_rx_byte == sum_reg) begin
                        state_next  = ST_READ;
                        rd_idx_next = '0;
                    end else begin
                        state_next = ST_HUNT;
                    end
                end
            end
            ST_READ: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                if (load) begin
                    if (rd_last) begin
                        state_next = ST_HUNT;
                    end else begin
                        rd_idx_next = rd_idx_reg + CntW'(1);
                        state_next  = ST_READ;
                    end
                end
            end
            default: begin
                state_next = ST_HUNT;
            end
        endcase
    end

    // control and frame state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_HUNT;
            remaining_reg  <= '0;
            stored_reg     <= '0;
            rd_idx_reg     <= '0;
            sum_reg        <= '0;
            func_reg       <= '0;
            hdr_first_reg  <= cfr_pkg::HEADER_FIRST_RST;
            hdr_second_reg <= cfr_pkg::HEADER_SECOND_RST;
        end else begin
            state_reg     <= state_next;
            remaining_reg <= remaining_next;
            stored_reg    <= stored_next;
            rd_idx_reg    <= rd_idx_next;
            sum_reg       <= sum_next;
            func_reg      <= func_next;
            if (cfg_we && (cfg_index == cfr_pkg::REG_HEADER_FIRST)) begin
                hdr_first_reg <= cfg_wdata;
            end
            if (cfg_we && (cfg_index == cfr_pkg::REG_HEADER_SECOND)) begin
                hdr_second_reg <= cfg_wdata;
            end
        end
    end

    // output register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge aclk) begin
        if (load) begin
            m_func_reg  <= func_reg;
            m_data_reg  <= ram_rdata;
            m_index_reg <= rd_idx_reg;
            m_last_reg  <= rd_last;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_function_code = m_func_reg;
    assign m_payload_byte  = m_data_reg;
    assign m_byte_index    = m_index_reg;
    assign m_last_byte     = m_last_reg;

    // a result is only loaded straight out of the ram load step
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_LOAD))
        else $error("result appeared without a ram load");

    // readout never addresses beyond the bytes stored in this frame
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |-> (rd_idx_reg < stored_reg))
        else $error("readout index beyond stored payload");

    // stored plus remaining stays below the length limit during payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PAYLOAD) |->
            ((7'(stored_reg) + 7'(remaining_reg)) < 7'(LENGTH_LIMIT)))
        else $error("payload count exceeds store depth");

    // a ram write only happens while collecting payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |=> ((state_reg == ST_PAYLOAD) || (state_reg == ST_CSUM)))
        else $error("payload write outside payload phase");

endmodule

`default_nettype wire

// ===== bench/tb_checksum_frame_receiver.sv =====
// self-checking testbench for the checksum frame receiver
module tb_checksum_frame_receiver;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BYTE_W           = cfr_pkg::BYTE_W;
    localparam int INDEX_W          = cfr_pkg::INDEX_W;
    localparam int CFG_IDX_W        = cfr_pkg::CFG_IDX_W;
    localparam int FRAME_LEN_LIMIT  = cfr_pkg::LENGTH_LIMIT_DEF;
    localparam int STORE_DEPTH      = FRAME_LEN_LIMIT - 1;
    localparam int DRAIN_CYCLES     = 20;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT      = 300000;

    // register indexes outside the map, writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    typedef enum logic [5:0] {
        RX_HUNT       = 6'b00_0001,
        RX_GOT_FIRST  = 6'b00_0010,
        RX_GOT_SECOND = 6'b00_0100,
        RX_GOT_FUNC   = 6'b00_1000,
        RX_PAYLOAD    = 6'b01_0000,
        RX_CHECKSUM   = 6'b10_0000
    } rx_phase_t;

    typedef enum {
        FLAW_NONE,
        FLAW_SUM,
        FLAW_FUNC,
        FLAW_LEN
    } frame_flaw_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  function_code;
        logic [BYTE_W-1:0]  payload_byte;
        logic [INDEX_W-1:0] byte_index;
        logic               last_byte;
    } frame_result_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [BYTE_W-1:0]    cfg_wdata = '0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    logic [BYTE_W-1:0]    s_rx_byte = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    logic [BYTE_W-1:0]    m_function_code;
    logic [BYTE_W-1:0]    m_payload_byte;
    logic [INDEX_W-1:0]   m_byte_index;
    logic                 m_last_byte;

    // header registers as the block should hold them
    logic [BYTE_W-1:0] cfg_hdr_first  = cfr_pkg::HEADER_FIRST_RST;
    logic [BYTE_W-1:0] cfg_hdr_second = cfr_pkg::HEADER_SECOND_RST;

    // deframer state
    rx_phase_t          rx_phase   = RX_HUNT;
    logic [INDEX_W-1:0] bytes_left = '0;
    logic [INDEX_W-1:0] bytes_kept = '0;
    logic [BYTE_W-1:0]  frame_sum  = '0;
    logic [BYTE_W-1:0]  frame_func = '0;
    logic [BYTE_W-1:0]  payload_mem [STORE_DEPTH];

    logic [BYTE_W-1:0] pending_rx_q [$];
    frame_result_t     expected_bytes_q [$];
    frame_result_t     want;

    int          items_queued   = 0;
    int          items_accepted = 0;
    int          error_count    = 0;
    int          cycle_count    = 0;
    int          send_wait      = 0;
    int          recv_wait      = 0;
    int          send_gap_max   = 9;
    int          recv_gap_max   = 9;
    logic        long_hold_req  = 1'b0;

    checksum_frame_receiver i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_function_code (m_function_code),
        .m_payload_byte  (m_payload_byte),
        .m_byte_index    (m_byte_index),
        .m_last_byte     (m_last_byte)
    );

    always #5 aclk = ~aclk;

    // advance the deframer by one received byte, queue any payload it releases
    function automatic void track_rx_byte(input logic [BYTE_W-1:0] b);
        frame_result_t r;
        if (rx_phase == RX_HUNT && b == cfg_hdr_first) begin
            rx_phase  = RX_GOT_FIRST;
            frame_sum = b;
        end else if (rx_phase == RX_GOT_FIRST && b == cfg_hdr_second) begin
            rx_phase  = RX_GOT_SECOND;
            frame_sum = frame_sum + b;
        end else if (rx_phase == RX_GOT_SECOND && b > cfr_pkg::FUNC_FLOOR) begin
            rx_phase   = RX_GOT_FUNC;
            frame_func = b;
            frame_sum  = frame_sum + b;
        end else if (rx_phase == RX_GOT_FUNC && b < FRAME_LEN_LIMIT) begin
            rx_phase   = RX_PAYLOAD;
            bytes_left = INDEX_W'(b);
            bytes_kept = '0;
            frame_sum  = frame_sum + b;
        end else if (rx_phase == RX_PAYLOAD && bytes_left != 0) begin
            payload_mem[bytes_kept] = b;
            bytes_kept = bytes_kept + 1'b1;
            bytes_left = bytes_left - 1'b1;
            frame_sum  = frame_sum + b;
            if (bytes_left == 0)
                rx_phase = RX_CHECKSUM;
        end else if (rx_phase == RX_CHECKSUM) begin
            rx_phase = RX_HUNT;
            // matching checksum releases the whole stored payload
            if (b == frame_sum) begin
                for (int k = 0; k < bytes_kept; k++) begin
                    r.function_code = frame_func;
                    r.payload_byte  = payload_mem[k];
                    r.byte_index    = INDEX_W'(k);
                    r.last_byte     = (k + 1 == bytes_kept);
                    expected_bytes_q.push_back(r);
                end
            end
        end else begin
            rx_phase = RX_HUNT;
        end
    endfunction

    task automatic push_rx(input logic [BYTE_W-1:0] b);
        pending_rx_q.push_back(b);
        items_queued++;
    endtask

    // function, length, payload and checksum; fill or func below zero means random
    task automatic push_frame_body(input logic [BYTE_W-1:0] head_sum, input int len,
                                   input frame_flaw_t flaw, input int fill, input int func);
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] fn;
        logic [BYTE_W-1:0] pay;
        sum = head_sum;
        if (func >= 0)
            fn = BYTE_W'(func);
        else if (flaw == FLAW_FUNC)
            fn = BYTE_W'($urandom_range(0, cfr_pkg::FUNC_FLOOR));
        else
            fn = BYTE_W'($urandom_range(cfr_pkg::FUNC_FLOOR + 1, 255));
        push_rx(fn);
        sum = sum + fn;
        if (flaw == FLAW_FUNC)
            return;
        push_rx(BYTE_W'(len));
        sum = sum + BYTE_W'(len);
        if (flaw == FLAW_LEN)
            return;
        for (int i = 0; i < len; i++) begin
            pay = (fill < 0) ? BYTE_W'($urandom) : BYTE_W'(fill);
            push_rx(pay);
            sum = sum + pay;
        end
        if (flaw == FLAW_SUM)
            sum = sum + BYTE_W'($urandom_range(1, 255));
        push_rx(sum);
    endtask

    task automatic push_frame(input int len, input frame_flaw_t flaw, input int fill,
                              input int func);
        push_rx(cfg_hdr_first);
        push_rx(cfg_hdr_second);
        push_frame_body(BYTE_W'(cfg_hdr_first + cfg_hdr_second), len, flaw, fill, func);
    endtask

    // mostly good frames with random content, the rest broken frames and noise
    task automatic queue_random_traffic(input int n_items);
        int start;
        int pick;
        int len;
        start = items_queued;
        while (items_queued - start < n_items) begin
            pick = $urandom_range(0, 19);
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, STORE_DEPTH)
                                                : $urandom_range(0, 8);
            if (pick <= 12)
                push_frame(len, FLAW_NONE, -1, -1);
            else if (pick <= 14)
                push_frame(len, FLAW_SUM, -1, -1);
            else if (pick == 15)
                push_frame(len, FLAW_FUNC, -1, -1);
            else if (pick == 16)
                push_frame($urandom_range(FRAME_LEN_LIMIT, 255), FLAW_LEN, -1, -1);
            else if (pick == 17) begin
                push_rx(cfg_hdr_first);
                push_rx(BYTE_W'($urandom));
            end else begin
                repeat ($urandom_range(1, 4))
                    push_rx(BYTE_W'($urandom));
            end
        end
    endtask

    task automatic write_header_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [BYTE_W-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            cfr_pkg::REG_HEADER_FIRST:  cfg_hdr_first  = val;
            cfr_pkg::REG_HEADER_SECOND: cfg_hdr_second = val;
            default: ;
        endcase
    endtask

    // everything sent and every expected transaction received, then let it settle
    task automatic wait_idle();
        while (items_accepted != items_queued || expected_bytes_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_wait = 0;
        end else begin
            if (s_valid && s_ready) begin
                track_rx_byte(s_rx_byte);
                items_accepted++;
            end
            // hold the offered byte until it is taken
            if (!(s_valid && !s_ready)) begin
                if (send_wait > 0) begin
                    send_wait--;
                    s_valid <= 1'b0;
                end else if (pending_rx_q.size() != 0) begin
                    s_rx_byte <= pending_rx_q.pop_front();
                    s_valid   <= 1'b1;
                    send_wait = $urandom_range(0, send_gap_max);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and checker
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_wait = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_bytes_q.size() == 0) begin
                    $error("unexpected transaction: payload_byte %0h index %0d",
                           m_payload_byte, m_byte_index);
                    error_count++;
                end else begin
                    want = expected_bytes_q.pop_front();
                    if (m_function_code !== want.function_code) begin
                        $error("function_code: expected %0h, got %0h",
                               want.function_code, m_function_code);
                        error_count++;
                    end
                    if (m_payload_byte !== want.payload_byte) begin
                        $error("payload_byte: expected %0h, got %0h",
                               want.payload_byte, m_payload_byte);
                        error_count++;
                    end
                    if (m_byte_index !== want.byte_index) begin
                        $error("byte_index: expected %0d, got %0d",
                               want.byte_index, m_byte_index);
                        error_count++;
                    end
                    if (m_last_byte !== want.last_byte) begin
                        $error("last_byte: expected %0b, got %0b",
                               want.last_byte, m_last_byte);
                        error_count++;
                    end
                end
                recv_wait = $urandom_range(0, recv_gap_max);
            end
            // long hold-off so the block backs up into its input
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                recv_wait = LONG_HOLD_CYCLES;
            end
            if (recv_wait > 0) begin
                recv_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // stimulus sequence
    initial begin
        logic [BYTE_W-1:0] head_sum;
        logic [BYTE_W-1:0] same_hdr;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed frames at the reset headers
        push_frame(1, FLAW_NONE, 8'h00, 8'hFF);
        push_frame(0, FLAW_NONE, -1, cfr_pkg::FUNC_FLOOR + 1);
        push_frame(1, FLAW_SUM, 8'hFF, -1);
        // second header test fails on a repeated first header, byte is not re-examined
        push_rx(cfg_hdr_first);
        push_rx(cfg_hdr_first);
        push_rx(cfg_hdr_second);
        push_frame(0, FLAW_FUNC, -1, cfr_pkg::FUNC_FLOOR);
        push_frame(FRAME_LEN_LIMIT, FLAW_LEN, -1, -1);
        wait_idle();

        // extreme headers, spare indexes must not disturb them
        write_header_reg(cfr_pkg::REG_HEADER_FIRST, 8'h00);
        write_header_reg(cfr_pkg::REG_HEADER_SECOND, 8'hFF);
        write_header_reg(REG_SPARE_LO, BYTE_W'($urandom));
        write_header_reg(REG_SPARE_HI, 8'hFF);
        queue_random_traffic(12);
        wait_idle();

        // swapped extremes with no idling on either side
        write_header_reg(cfr_pkg::REG_HEADER_FIRST, 8'hFF);
        write_header_reg(cfr_pkg::REG_HEADER_SECOND, 8'h00);
        send_gap_max = 0;
        recv_gap_max = 0;
        queue_random_traffic(12);
        wait_idle();

        // headers change after a frame's headers were already taken
        head_sum = cfg_hdr_first + cfg_hdr_second;
        push_rx(cfg_hdr_first);
        push_rx(cfg_hdr_second);
        wait_idle();
        write_header_reg(cfr_pkg::REG_HEADER_FIRST, BYTE_W'($urandom));
        write_header_reg(cfr_pkg::REG_HEADER_SECOND, BYTE_W'($urandom));
        send_gap_max = 9;
        push_frame_body(head_sum, 3, FLAW_NONE, -1, -1);
        queue_random_traffic(12);
        wait_idle();

        // both headers equal
        same_hdr = BYTE_W'($urandom);
        write_header_reg(cfr_pkg::REG_HEADER_FIRST, same_hdr);
        write_header_reg(cfr_pkg::REG_HEADER_SECOND, same_hdr);
        send_gap_max = 0;
        recv_gap_max = 9;
        queue_random_traffic(12);
        wait_idle();

        // receiver stalls while a full-length frame and more keep coming
        write_header_reg(cfr_pkg::REG_HEADER_FIRST, cfr_pkg::HEADER_FIRST_RST);
        write_header_reg(cfr_pkg::REG_HEADER_SECOND, cfr_pkg::HEADER_SECOND_RST);
        send_gap_max  = 0;
        long_hold_req = 1'b1;
        push_frame(STORE_DEPTH, FLAW_NONE, -1, -1);
        queue_random_traffic(8);
        wait_idle();

        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
